[rtl/stq_pkg.sv]
// Package with the types, codes and constants of the sorted timeout queue.
`timescale 1ns / 1ps

package stq_pkg;

	// Default queue depth.
	localparam int DEFAULT_NUM_TIMERS = 8;

	// Stream widths: input tdata holds 146 bits of fields padded to 19 bytes,
	// output tdata holds 47 bits of fields padded to 6 bytes.
	localparam int S_TDATA_W = 152;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 48;

	// One second in microseconds, wide enough for the sum of two microsecond fields.
	localparam logic [20:0] USEC_PER_SEC = 21'd1000000;

	// Request codes carried in s_tuser; codes five to seven mean nothing.
	localparam logic [2:0] REQ_REGISTER = 3'd0;
	localparam logic [2:0] REQ_CANCEL   = 3'd1;
	localparam logic [2:0] REQ_QUERY    = 3'd2;
	localparam logic [2:0] REQ_TICK     = 3'd3;
	localparam logic [2:0] REQ_CLEAR    = 3'd4;

	localparam logic [3:0] REMOVED_MAX = 4'd15;

	// One stored timeout.
	typedef struct packed {
		logic [31:0] sec;
		logic [19:0] usec;
		logic [7:0]  handler;
		logic [15:0] event_ctx;
		logic [15:0] user_ctx;
	} entry_t;

	// One result, declared so that status lands in the lowest bit.
	typedef struct packed {
		logic [15:0] fired_user_ctx;
		logic [15:0] fired_event_ctx;
		logic [7:0]  fired_handler;
		logic        fired;
		logic        found;
		logic [3:0]  removed_count;
		logic        status;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_RD,
		ST_EV,
		ST_INS,
		ST_OUT
	} state_t;

endpackage

[rtl/sorted_timeout_queue.sv]
// Top level of the sorted timeout queue: sequencer, entry memory and result register.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid / s_tready  s_tuser = request code, s_tdata = request fields
// m_*      out        m_tvalid / m_tready  m_tdata = result fields
//
// Per request: register takes 0 to 2 normalisation steps and then compares stored entries,
// every entry it goes in front of plus the one it stops behind, if any; cancel and tick
// walk every stored entry; query stops at the first hit; clear and a refused register
// walk no entries. The single entry memory is read once and evaluated once for every
// entry walked, through one shared comparator.
// Reset clears the control state and the entry count; the entry memory is not cleared,
// since the count alone decides which entries are live.
// The block takes one request at a time. A finished result waits in the output register
// while the next request is taken; a request that finishes before the previous result has
// been taken waits until it has.

module sorted_timeout_queue
	import stq_pkg::*;
#(
	parameter int NUM_TIMERS = DEFAULT_NUM_TIMERS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// From bit 0: now_sec[32], now_usec[20], delay_sec[32], delay_usec[20], handler_tag[8],
	// event_ctx[16], user_ctx[16], any_event_ctx[1], any_user_ctx[1], zero padding.
	input  logic [S_TDATA_W-1:0] s_tdata,
	// From bit 0: req_type[3].
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// From bit 0: status[1], removed_count[4], found[1], fired[1], fired_handler[8],
	// fired_event_ctx[16], fired_user_ctx[16], zero padding.
	output logic [M_TDATA_W-1:0] m_tdata
);

	// Index width addresses the memory; count width can also hold a full queue.
	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(NUM_TIMERS);

	// Entry memory: one write port, one registered read port.
	entry_t          mem [NUM_TIMERS];
	entry_t          rd_q;
	logic            mem_we;
	logic [IW-1:0]   mem_waddr;
	entry_t          mem_wdata;
	logic [IW-1:0]   mem_raddr;
	logic            mem_re;

	state_t          state_q, state_d;

	// Request captured at acceptance.
	logic [2:0]      op_q;
	logic [31:0]     dl_sec_q;    // new deadline for register, current time for tick
	logic [20:0]     dl_usec_q;
	logic [7:0]      hd_q;
	logic [15:0]     ec_q;
	logic [15:0]     uc_q;
	logic            any_e_q;
	logic            any_u_q;

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;       // read index of a scan, or the entry being moved past
	logic [CW-1:0]   wr_q;        // compaction write index
	logic [CW-1:0]   ins_pos_q;
	result_t         res_q;
	result_t         out_q;
	logic            out_valid_q;

	logic            accept;
	logic [CW-1:0]   idx_inc;
	logic [CW-1:0]   wr_next;
	logic            cmp_earlier;
	logic            tag_match;
	logic            hit;
	logic            scan_last;
	logic            norm_done;

	assign accept    = s_tvalid && s_tready;
	assign idx_inc   = idx_q + CW'(1);
	assign scan_last = (idx_inc == count_q);
	assign norm_done = (dl_usec_q < USEC_PER_SEC);

	// The one comparator: is the held deadline (or time) strictly earlier than the entry read?
	assign cmp_earlier = (dl_sec_q < rd_q.sec) ||
		((dl_sec_q == rd_q.sec) && (dl_usec_q < {1'b0, rd_q.usec}));

	// Tag match; for a query both wildcards were cleared when the request was captured.
	assign tag_match = (rd_q.handler == hd_q) &&
		(any_e_q || (rd_q.event_ctx == ec_q)) &&
		(any_u_q || (rd_q.user_ctx == uc_q));

	// A tick removes only the head, and only when its deadline is not later than now.
	assign hit     = (op_q == REQ_TICK) ? ((idx_q == '0) && !cmp_earlier) : tag_match;
	assign wr_next = hit ? wr_q : (wr_q + CW'(1));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (s_tuser)
						REQ_REGISTER: state_d = (count_q == FULL_COUNT) ? ST_OUT : ST_NORM;
						REQ_CANCEL, REQ_QUERY, REQ_TICK: state_d = (count_q == '0) ? ST_OUT : ST_RD;
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_NORM: begin
				if (norm_done) begin
					state_d = (count_q == '0) ? ST_INS : ST_RD;
				end
			end
			ST_RD: state_d = ST_EV;
			ST_EV: begin
				unique case (op_q)
					REQ_REGISTER: begin
						if (cmp_earlier && (idx_q != '0)) begin
							state_d = ST_RD;
						end else begin
							state_d = ST_INS;
						end
					end
					REQ_QUERY: state_d = (tag_match || scan_last) ? ST_OUT : ST_RD;
					default: state_d = scan_last ? ST_OUT : ST_RD;
				endcase
			end
			ST_INS: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = idx_q[IW-1:0];
		mem_we    = 1'b0;
		mem_waddr = idx_inc[IW-1:0];
		mem_wdata = rd_q;
		unique case (state_q)
			ST_RD: mem_re = 1'b1;
			ST_EV: begin
				if (op_q == REQ_REGISTER) begin
					// Later entries shift up by one to open the gap.
					mem_we = cmp_earlier;
				end else if (op_q == REQ_CANCEL || op_q == REQ_TICK) begin
					// Kept entries close up over removed ones.
					mem_we    = !hit && (wr_q != idx_q);
					mem_waddr = wr_q[IW-1:0];
				end
			end
			ST_INS: begin
				mem_we    = 1'b1;
				mem_waddr = ins_pos_q[IW-1:0];
				mem_wdata = '{sec: dl_sec_q, usec: dl_usec_q[19:0], handler: hd_q,
					event_ctx: ec_q, user_ctx: uc_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A new result may replace the one being taken in the same cycle.
			if ((state_q == ST_OUT) && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser == REQ_CLEAR) begin
						count_q <= '0;
					end
				end
				ST_EV: begin
					if ((op_q == REQ_CANCEL || op_q == REQ_TICK) && scan_last) begin
						count_q <= wr_next;
					end
				end
				ST_INS: count_q <= count_q + CW'(1);
				default: begin
				end
			endcase
		end
	end

	// Request and scan data path.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q      <= s_tuser;
					hd_q      <= s_tdata[111:104];
					ec_q      <= s_tdata[127:112];
					uc_q      <= s_tdata[143:128];
					any_e_q   <= (s_tuser == REQ_CANCEL) && s_tdata[144];
					any_u_q   <= (s_tuser == REQ_CANCEL) && s_tdata[145];
					idx_q     <= (s_tuser == REQ_REGISTER) ? (count_q - CW'(1)) : '0;
					wr_q      <= '0;
					ins_pos_q <= '0;
					// Every result field starts at zero; a register on a full queue is refused.
					res_q     <= {{($bits(result_t) - 1){1'b0}},
						(s_tuser == REQ_REGISTER) && (count_q == FULL_COUNT)};
					if (s_tuser == REQ_REGISTER) begin
						dl_sec_q  <= s_tdata[31:0] + s_tdata[83:52];
						dl_usec_q <= {1'b0, s_tdata[51:32]} + {1'b0, s_tdata[103:84]};
					end else begin
						dl_sec_q  <= s_tdata[31:0];
						dl_usec_q <= {1'b0, s_tdata[51:32]};
					end
				end
			end
			ST_NORM: begin
				if (!norm_done) begin
					dl_usec_q <= dl_usec_q - USEC_PER_SEC;
					dl_sec_q  <= dl_sec_q + 32'd1;
				end
			end
			ST_EV: begin
				unique case (op_q)
					REQ_REGISTER: begin
						if (!cmp_earlier) begin
							ins_pos_q <= idx_inc;
						end else if (idx_q != '0) begin
							idx_q <= idx_q - CW'(1);
						end
					end
					REQ_QUERY: begin
						res_q.found <= tag_match;
						idx_q       <= idx_inc;
					end
					default: begin
						if (hit) begin
							if (op_q == REQ_TICK) begin
								res_q.fired           <= 1'b1;
								res_q.fired_handler   <= rd_q.handler;
								res_q.fired_event_ctx <= rd_q.event_ctx;
								res_q.fired_user_ctx  <= rd_q.user_ctx;
							end else if (res_q.removed_count != REMOVED_MAX) begin
								res_q.removed_count <= res_q.removed_count + 4'd1;
							end
						end
						wr_q  <= wr_next;
						idx_q <= idx_inc;
					end
				endcase
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/stq_checker.sv]
// Port checker for the sorted timeout queue, bound to the top level.
`timescale 1ns / 1ps

module stq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [47:0]  m_tdata
);

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Each request is worked on alone, so the input closes after a transaction.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in progress");

	// A result reports at most one kind of outcome.
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0({m_tdata[0], m_tdata[4:1] != 4'd0, m_tdata[5], m_tdata[6]}))
		else $error("result mixes outcomes of different requests");

	// Popped tags only appear alongside a fired timeout.
	a_tags_need_fire: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[6] |-> m_tdata[46:7] == 40'd0)
		else $error("tags reported without a fired timeout");

endmodule

bind sorted_timeout_queue stq_checker u_stq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
